// ----- hdl/nts_pkg.sv -----
// Shared types, codes and control structs for the note table block.
`default_nettype none
package nts_pkg;

  localparam int unsigned IDX_W = 5;

  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_FIND  = 3'd1,
    MODE_RANGE = 3'd2,
    MODE_SORT  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    WS_INPUT  = 2'd0,
    WS_RDATA  = 2'd1,
    WS_HELD   = 2'd2,
    WS_CLRMOD = 2'd3
  } wsel_e;

  typedef enum logic {
    KIND_INDEX   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] stop;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic        modified;
    logic        selected;
  } note_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] time_a;
    logic [31:0] time_b;
    logic [6:0]  key_a;
    logic [6:0]  key_b;
    logic [6:0]  velocity;
    logic        modified;
    logic        selected;
  } in_t;

  typedef struct packed {
    logic  in_ready;
    logic  rd_en;
    logic  wr_en;
    wsel_e wsel;
    logic  hold;
    logic  cnt_inc;
    logic  cnt_clr;
    logic  acc_init;
    logic  acc;
    logic  emit;
    kind_e kind;
    logic  found;
    logic  status;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic  in_accept;
    logic  out_free;
    mode_e mode;
    logic  find_hit;
    logic  rng_skip;
    logic  rng_stop;
    logic  sort_before;
    logic  rd_mod;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/nts_in_if.sv -----
// Input item channel.
`default_nettype none
interface nts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] time_a;
  logic [31:0] time_b;
  logic [6:0]  key_a;
  logic [6:0]  key_b;
  logic [6:0]  velocity;
  logic        modified_in;
  logic        selected_in;
  modport source (output valid, mode, time_a, time_b, key_a, key_b, velocity,
                  modified_in, selected_in, input ready);
  modport sink (input valid, mode, time_a, time_b, key_a, key_b, velocity,
                modified_in, selected_in, output ready);
endinterface
`default_nettype wire

// ----- hdl/nts_out_if.sv -----
// Result item channel.
`default_nettype none
interface nts_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [4:0]  note_index;
  logic        found;
  logic        status;
  logic        last;
  logic [31:0] longest_end;
  logic [7:0]  lowest_key;
  logic [6:0]  highest_key;
  logic [5:0]  num_selected;
  modport source (output valid, result_kind, note_index, found, status, last,
                  longest_end, lowest_key, highest_key, num_selected, input ready);
  modport sink (input valid, result_kind, note_index, found, status, last,
                longest_end, lowest_key, highest_key, num_selected, output ready);
endinterface
`default_nettype wire

// ----- hdl/nts_cfg_if.sv -----
// Configuration write channel for key_limit.
`default_nettype none
interface nts_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_limit;
  modport source (output valid, key_limit, input ready);
  modport sink (input valid, key_limit, output ready);
endinterface
`default_nettype wire

// ----- hdl/nts_datapath.sv -----
// Note memory, input register, comparators, summary registers, output register.
`default_nettype none
module nts_datapath #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  nts_in_if.sink           in_i,
  nts_out_if.source        out_o,
  nts_cfg_if.sink          cfg_i,
  input  nts_pkg::cmd_t    cmd_i,
  input  wire [CW-1:0]     rd_addr_i,
  input  wire [CW-1:0]     wr_addr_i,
  input  wire [CW-1:0]     emit_idx_i,
  output nts_pkg::sts_t    sts_o,
  output logic [CW-1:0]    count_o
);
  import nts_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  note_t       mem [TABLE_DEPTH];
  note_t       rdata_q;
  note_t       held_q;
  note_t       wdata;
  in_t         in_q;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]  key_limit_q;
  logic [31:0] longest_q;
  logic [7:0]  low_q;
  logic [6:0]  high_q;
  logic [5:0]  sel_q;
  logic        out_valid_q;
  logic        out_kind_q, out_found_q, out_status_q, out_last_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [31:0] out_longest_q;
  logic [7:0]  out_low_q;
  logic [6:0]  out_high_q;
  logic [5:0]  out_sel_q;
  logic [CW+IDX_W-1:0] idx_ext;
  logic        accept;
  logic        out_free;

  assign accept   = in_i.valid & cmd_i.in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;
  assign count_o = count_q;
  assign idx_ext = {{IDX_W{1'b0}}, emit_idx_i};

  always_comb begin
    case (cmd_i.wsel)
      WS_INPUT:  wdata = '{start: in_q.time_a, stop: in_q.time_b, key: in_q.key_a,
                           velocity: in_q.velocity, modified: in_q.modified,
                           selected: in_q.selected};
      WS_RDATA:  wdata = rdata_q;
      WS_HELD:   wdata = held_q;
      WS_CLRMOD: begin
        wdata = rdata_q;
        wdata.modified = 1'b0;
      end
      default:   wdata = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_i[AW-1:0]];
    end
    if (cmd_i.hold) begin
      held_q <= rdata_q;
    end
    if (accept) begin
      in_q <= '{mode: in_i.mode, time_a: in_i.time_a, time_b: in_i.time_b,
                key_a: in_i.key_a, key_b: in_i.key_b, velocity: in_i.velocity,
                modified: in_i.modified_in, selected: in_i.selected_in};
    end
    if (cmd_i.emit) begin
      out_kind_q    <= cmd_i.kind;
      out_idx_q     <= idx_ext[IDX_W-1:0];
      out_found_q   <= cmd_i.found;
      out_status_q  <= cmd_i.status;
      out_last_q    <= cmd_i.last;
      out_longest_q <= (cmd_i.kind == KIND_SUMMARY) ? longest_q : '0;
      out_low_q     <= (cmd_i.kind == KIND_SUMMARY) ? low_q : '0;
      out_high_q    <= (cmd_i.kind == KIND_SUMMARY) ? high_q : '0;
      out_sel_q     <= (cmd_i.kind == KIND_SUMMARY) ? sel_q : '0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      key_limit_q <= 8'd128;
      longest_q   <= '0;
      low_q       <= '0;
      high_q      <= '0;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_i.valid) begin
        key_limit_q <= cfg_i.key_limit;
      end
      if (cmd_i.acc_init) begin
        low_q  <= key_limit_q;
        high_q <= '0;
        sel_q  <= '0;
      end else if (cmd_i.acc) begin
        if (rdata_q.stop > longest_q) longest_q <= rdata_q.stop;
        if ({1'b0, rdata_q.key} < low_q) low_q <= {1'b0, rdata_q.key};
        if (rdata_q.key > high_q) high_q <= rdata_q.key;
        if (rdata_q.selected) sel_q <= sel_q + 6'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = out_kind_q;
  assign out_o.note_index     = out_idx_q;
  assign out_o.found          = out_found_q;
  assign out_o.status         = out_status_q;
  assign out_o.last           = out_last_q;
  assign out_o.longest_end    = out_longest_q;
  assign out_o.lowest_key     = out_low_q;
  assign out_o.highest_key    = out_high_q;
  assign out_o.num_selected   = out_sel_q;

  always_comb begin
    sts_o.in_accept = accept;
    sts_o.out_free  = out_free;
    sts_o.mode      = mode_e'(in_q.mode);
    sts_o.find_hit  = (in_q.time_a >= rdata_q.start) && (in_q.time_a < rdata_q.stop)
                      && (rdata_q.key == in_q.key_a);
    sts_o.rng_skip  = (rdata_q.stop < in_q.time_a) || (rdata_q.key < in_q.key_a)
                      || (rdata_q.key > in_q.key_b);
    sts_o.rng_stop  = rdata_q.start > in_q.time_b;
    // held entry strictly before the one just read: start, then key, then velocity
    sts_o.sort_before = (held_q.start != rdata_q.start) ? (held_q.start < rdata_q.start) :
                        (held_q.key != rdata_q.key) ? (held_q.key < rdata_q.key) :
                        (held_q.velocity < rdata_q.velocity);
    sts_o.rd_mod    = rdata_q.modified;
  end

endmodule
`default_nettype wire

// ----- hdl/nts_ctrl.sv -----
// Sequencer for load, clear, find, range scan, insertion sort and summary pass.
`default_nettype none
module nts_ctrl #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  nts_pkg::sts_t   sts_i,
  input  wire [CW-1:0]    count_i,
  output nts_pkg::cmd_t   cmd_o,
  output logic [CW-1:0]   rd_addr_o,
  output logic [CW-1:0]   wr_addr_o,
  output logic [CW-1:0]   emit_idx_o
);
  import nts_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_SCAN_RD, ST_SCAN_CHK, ST_FINAL,
    ST_SRT_RDI, ST_SRT_HOLD, ST_SRT_RDJ, ST_SRT_CMP, ST_SRT_WR,
    ST_SUM_RD, ST_SUM_CHK, ST_SUM_OUT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, pend_idx_q, pend_idx_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] i_nxt;

  assign i_nxt = i_q + CW'(1);

  always_comb begin
    cmd_o      = '0;
    rd_addr_o  = i_q;
    wr_addr_o  = j_q;
    emit_idx_o = '0;
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        i_d    = '0;
        pend_d = 1'b0;
        case (sts_i.mode)
          MODE_LOAD: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
              if (count_i == CW'(TABLE_DEPTH)) begin
                cmd_o.status = 1'b1;
              end else begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.wsel    = WS_INPUT;
                wr_addr_o     = count_i;
                cmd_o.cnt_inc = 1'b1;
                cmd_o.found   = 1'b1;
                emit_idx_o    = count_i;
              end
              state_d = ST_IDLE;
            end
          end
          MODE_CLEAR: begin
            if (sts_i.out_free) begin
              cmd_o.cnt_clr = 1'b1;
              cmd_o.emit    = 1'b1;
              cmd_o.last    = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          MODE_FIND, MODE_RANGE: begin
            state_d = (count_i == '0) ? ST_FINAL : ST_SCAN_RD;
          end
          MODE_SORT: begin
            cmd_o.acc_init = 1'b1;
            if (count_i <= CW'(1)) begin
              state_d = ST_SUM_RD;
            end else begin
              i_d     = CW'(1);
              state_d = ST_SRT_RDI;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SCAN_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (sts_i.mode == MODE_FIND) begin
          if (sts_i.find_hit) begin
            if (sts_i.out_free) begin
              cmd_o.emit  = 1'b1;
              cmd_o.found = 1'b1;
              cmd_o.last  = 1'b1;
              emit_idx_o  = i_q;
              state_d     = ST_IDLE;
            end
          end else begin
            i_d     = i_nxt;
            state_d = (i_nxt == count_i) ? ST_FINAL : ST_SCAN_RD;
          end
        end else if (sts_i.rng_skip) begin
          i_d     = i_nxt;
          state_d = (i_nxt == count_i) ? ST_FINAL : ST_SCAN_RD;
        end else if (sts_i.rng_stop) begin
          state_d = ST_FINAL;
        end else if (!pend_q || sts_i.out_free) begin
          // previous match goes out now; this one waits to learn if it is the last
          cmd_o.emit  = pend_q;
          cmd_o.found = 1'b1;
          emit_idx_o  = pend_idx_q;
          pend_d      = 1'b1;
          pend_idx_d  = i_q;
          i_d         = i_nxt;
          state_d     = (i_nxt == count_i) ? ST_FINAL : ST_SCAN_RD;
        end
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.found = pend_q;
          cmd_o.last  = 1'b1;
          emit_idx_o  = pend_q ? pend_idx_q : '0;
          pend_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      ST_SRT_RDI: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SRT_HOLD;
      end
      ST_SRT_HOLD: begin
        cmd_o.hold = 1'b1;
        j_d        = i_q;
        state_d    = ST_SRT_RDJ;
      end
      ST_SRT_RDJ: begin
        if (j_q == '0) begin
          state_d = ST_SRT_WR;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = j_q - CW'(1);
          state_d     = ST_SRT_CMP;
        end
      end
      ST_SRT_CMP: begin
        if (sts_i.sort_before) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wsel  = WS_RDATA;
          j_d         = j_q - CW'(1);
          state_d     = ST_SRT_RDJ;
        end else begin
          state_d = ST_SRT_WR;
        end
      end
      ST_SRT_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsel  = WS_HELD;
        if (i_nxt == count_i) begin
          i_d     = '0;
          state_d = ST_SUM_RD;
        end else begin
          i_d     = i_nxt;
          state_d = ST_SRT_RDI;
        end
      end
      ST_SUM_RD: begin
        if (i_q == count_i) begin
          state_d = ST_SUM_OUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_SUM_CHK;
        end
      end
      ST_SUM_CHK: begin
        if (!sts_i.rd_mod || sts_i.out_free) begin
          cmd_o.acc = 1'b1;
          if (sts_i.rd_mod) begin
            cmd_o.emit  = 1'b1;
            cmd_o.found = 1'b1;
            emit_idx_o  = i_q;
            cmd_o.wr_en = 1'b1;
            cmd_o.wsel  = WS_CLRMOD;
            wr_addr_o   = i_q;
          end
          i_d     = i_nxt;
          state_d = ST_SUM_RD;
        end
      end
      ST_SUM_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_SUMMARY;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      pend_q     <= pend_d;
      pend_idx_q <= pend_idx_d;
    end
  end

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("result loaded over a waiting one");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> !cmd_o.in_ready) else $error("table written while idle");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_q) else $error("pending match left behind");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE)) else $error("last not final");

endmodule
`default_nettype wire

// ----- hdl/note_table_search_sort.sv -----
// Top level of the note table with search and sort.
//
//  channel  dir  handshake      carries
//  in_i     in   valid/ready    mode, times, keys, velocity, marks
//  out_o    out  valid/ready    index/ack or summary item
//  cfg_i    in   valid/ready    key_limit (always ready)
//
// One item at a time. Sort: insertion sort over one note memory, then a summary pass
// over the notes.
// Reset empties the table; no clearing pass. A stalled output holds the sequencer.
`default_nettype none
module note_table_search_sort #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  nts_in_if.sink     in_i,
  nts_out_if.source  out_o,
  nts_cfg_if.sink    cfg_i
);
  import nts_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] rd_addr, wr_addr, emit_idx, count;

  nts_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW)) u_ctrl (
    .clk_i, .rst_ni, .sts_i(sts), .count_i(count), .cmd_o(cmd),
    .rd_addr_o(rd_addr), .wr_addr_o(wr_addr), .emit_idx_o(emit_idx)
  );

  nts_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW)) u_dp (
    .clk_i, .rst_ni, .in_i, .out_o, .cfg_i, .cmd_i(cmd),
    .rd_addr_i(rd_addr), .wr_addr_i(wr_addr), .emit_idx_i(emit_idx),
    .sts_o(sts), .count_o(count)
  );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the note table with search and sort.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nts_pkg::*;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] time_a;
    logic [31:0] time_b;
    logic [6:0]  key_a;
    logic [6:0]  key_b;
    logic [6:0]  velocity;
    logic        modified;
    logic        selected;
  } cmd_item_t;

  typedef struct {
    logic        kind;
    logic [4:0]  index;
    logic        found;
    logic        status;
    logic        last;
    logic [31:0] longest;
    logic [7:0]  low_key;
    logic [6:0]  high_key;
    logic [5:0]  sel_count;
  } result_t;

  localparam int DEPTH = 32;
  localparam int LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nts_in_if  in_ch();
  nts_out_if out_ch();
  nts_cfg_if cfg_ch();

  note_table_search_sort #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  // model of the table
  note_t       tbl[DEPTH];
  int unsigned tbl_cnt;
  logic [31:0] longest_seen;
  logic [7:0]  key_limit;

  cmd_item_t pending_q[$];
  result_t   expected_q[$];
  int        errors;
  int        send_idle_pct, recv_stall_pct;
  logic      hold_send;
  int        cycles;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_expected(result_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic void queue_item(cmd_item_t c);
    pending_q = {pending_q, c};
  endfunction

  function automatic result_t idx_result(int idx, bit fnd, bit st, bit lst);
    result_t r;
    r = '{default: '0};
    r.index = idx[4:0];
    r.found = fnd;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  function automatic bit note_precedes(note_t a, note_t b);
    if (a.start != b.start) return a.start < b.start;
    if (a.key != b.key) return a.key < b.key;
    return a.velocity < b.velocity;
  endfunction

  // computes the results of one accepted item and updates the table model
  task automatic predict_table_op(cmd_item_t c);
    int k;
    int j;
    note_t t;
    result_t r;
    logic [7:0] lo;
    logic [6:0] hi;
    logic [5:0] cnt;
    k = 0;
    case (c.mode)
      MODE_LOAD: begin
        if (tbl_cnt >= DEPTH) begin
          add_expected(idx_result(0, 0, 1, 1));
        end else begin
          tbl[tbl_cnt] = '{c.time_a, c.time_b, c.key_a, c.velocity, c.modified, c.selected};
          add_expected(idx_result(tbl_cnt, 1, 0, 1));
          tbl_cnt++;
        end
      end
      MODE_CLEAR: begin
        tbl_cnt = 0;
        add_expected(idx_result(0, 0, 0, 1));
      end
      MODE_FIND: begin
        j = -1;
        for (int i = 0; i < tbl_cnt; i++)
          if (j < 0 && c.time_a >= tbl[i].start && c.time_a < tbl[i].stop &&
              tbl[i].key == c.key_a) j = i;
        add_expected(j < 0 ? idx_result(0, 0, 0, 1) : idx_result(j, 1, 0, 1));
      end
      MODE_RANGE: begin
        for (int i = 0; i < tbl_cnt; i++) begin
          if (tbl[i].stop < c.time_a || tbl[i].key < c.key_a || tbl[i].key > c.key_b)
            continue;
          if (tbl[i].start > c.time_b) break;
          add_expected(idx_result(i, 1, 0, 0));
          k++;
        end
        if (k == 0) add_expected(idx_result(0, 0, 0, 1));
        else expected_q[$].last = 1'b1;
      end
      MODE_SORT: begin
        for (int i = 1; i < tbl_cnt; i++) begin
          j = i;
          while (j > 0 && note_precedes(tbl[j], tbl[j-1])) begin
            t = tbl[j]; tbl[j] = tbl[j-1]; tbl[j-1] = t;
            j--;
          end
        end
        lo = key_limit;
        hi = '0;
        cnt = '0;
        for (int i = 0; i < tbl_cnt; i++) begin
          if (tbl[i].stop > longest_seen) longest_seen = tbl[i].stop;
          if ({1'b0, tbl[i].key} < lo) lo = {1'b0, tbl[i].key};
          if (tbl[i].key > hi) hi = tbl[i].key;
          if (tbl[i].modified) begin
            tbl[i].modified = 1'b0;
            add_expected(idx_result(i, 1, 0, 0));
          end
          if (tbl[i].selected) cnt++;
        end
        r = '{default: '0};
        r.kind = KIND_SUMMARY;
        r.last = 1'b1;
        r.longest = longest_seen;
        r.low_key = lo;
        r.high_key = hi;
        r.sel_count = cnt;
        add_expected(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_table_op('{in_ch.mode, in_ch.time_a, in_ch.time_b, in_ch.key_a,
                           in_ch.key_b, in_ch.velocity, in_ch.modified_in,
                           in_ch.selected_in});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          cmd_item_t c;
          c = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= c.mode;
          in_ch.time_a <= c.time_a;
          in_ch.time_b <= c.time_b;
          in_ch.key_a <= c.key_a;
          in_ch.key_b <= c.key_b;
          in_ch.velocity <= c.velocity;
          in_ch.modified_in <= c.modified;
          in_ch.selected_in <= c.selected;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", out_ch.note_index, 0);
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (out_ch.result_kind !== e.kind) report_mismatch("result_kind", out_ch.result_kind, e.kind);
          if (out_ch.note_index !== e.index) report_mismatch("note_index", out_ch.note_index, e.index);
          if (out_ch.found !== e.found) report_mismatch("found", out_ch.found, e.found);
          if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
          if (out_ch.last !== e.last) report_mismatch("last", out_ch.last, e.last);
          if (out_ch.longest_end !== e.longest) report_mismatch("longest_end", out_ch.longest_end, e.longest);
          if (out_ch.lowest_key !== e.low_key) report_mismatch("lowest_key", out_ch.lowest_key, e.low_key);
          if (out_ch.highest_key !== e.high_key) report_mismatch("highest_key", out_ch.highest_key, e.high_key);
          if (out_ch.num_selected !== e.sel_count)
            report_mismatch("num_selected", out_ch.num_selected, e.sel_count);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_time();
    case ($urandom_range(3))
      0: return 32'(($urandom_range(40)) << 16);
      1: return $urandom();
      2: return {16'($urandom_range(3)), 16'($urandom())};
      default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  function automatic cmd_item_t rand_note();
    cmd_item_t c;
    c.mode = MODE_LOAD;
    c.time_a = rand_time();
    c.time_b = $urandom_range(4) == 0 ? rand_time() : c.time_a + 32'($urandom_range(8) << 16)
               + 32'($urandom_range(65535));
    c.key_a = $urandom_range(3) == 0 ? 7'($urandom()) : 7'(60 + $urandom_range(6));
    c.key_b = 7'($urandom());
    c.velocity = $urandom_range(1) ? 7'($urandom()) : 7'($urandom_range(2));
    c.modified = 1'($urandom());
    c.selected = 1'($urandom());
    return c;
  endfunction

  function automatic cmd_item_t rand_query();
    cmd_item_t c;
    c = rand_note();
    c.mode = mode_e'($urandom_range(1, 4));
    if (c.mode == MODE_RANGE && $urandom_range(1)) begin
      c.key_a = 7'(55 + $urandom_range(8));
      c.key_b = 7'(c.key_a + $urandom_range(10));
    end
    return c;
  endfunction

  task automatic push(logic [2:0] m, logic [31:0] ta, logic [31:0] tb_, logic [6:0] ka,
                      logic [6:0] kb, logic [6:0] v, logic md, logic sl);
    cmd_item_t c;
    c = '{m, ta, tb_, ka, kb, v, md, sl};
    queue_item(c);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_key_limit(logic [7:0] v);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.key_limit <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    key_limit = v;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    cmd_item_t c;
    int n;
    errors = 0;
    cycles = 0;
    tbl_cnt = 0;
    longest_seen = '0;
    key_limit = 8'd128;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_send = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.time_a = '0;
    in_ch.time_b = '0;
    in_ch.key_a = '0;
    in_ch.key_b = '0;
    in_ch.velocity = '0;
    in_ch.modified_in = 1'b0;
    in_ch.selected_in = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.key_limit = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, unused mode
    push(MODE_SORT, 0, 0, 0, 0, 0, 0, 0);
    push(MODE_FIND, 0, 0, 0, 0, 0, 0, 0);
    push(MODE_RANGE, 0, '1, 0, 127, 0, 0, 0);
    push(MODE_LOAD, '1, '1, 127, 0, 127, 1, 1);
    push(MODE_LOAD, 0, '1, 0, 127, 0, 1, 0);
    push(MODE_LOAD, 32'h0001_0000, 32'h0002_0000, 60, 0, 5, 0, 1);
    push(MODE_LOAD, 32'h0001_0000, 32'h0003_0000, 60, 0, 4, 1, 0);
    push(3'd5, 0, 0, 0, 0, 0, 0, 0);
    push(3'd7, '1, '1, 127, 127, 127, 1, 1);
    push(MODE_FIND, 32'h0001_8000, 0, 60, 0, 0, 0, 0);
    push(MODE_FIND, 32'h0002_0000, 0, 61, 0, 0, 0, 0);
    push(MODE_RANGE, 0, '1, 0, 127, 0, 0, 0);
    push(MODE_RANGE, 32'h0002_0000, 32'h0001_0000, 60, 60, 0, 0, 0);
    push(MODE_RANGE, 0, '1, 100, 10, 0, 0, 0);
    push(MODE_SORT, 0, 0, 0, 0, 0, 0, 0);
    push(MODE_SORT, 0, 0, 0, 0, 0, 0, 0);
    push(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    push(MODE_SORT, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < DEPTH + 1; i++) queue_item(rand_note());
    push(MODE_SORT, 0, 0, 0, 0, 0, 0, 0);
    push(MODE_RANGE, 0, '1, 0, 127, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; write_key_limit(8'd0); end
        1: begin send_idle_pct = 48; recv_stall_pct = 0; write_key_limit(8'd128); end
        2: begin send_idle_pct = 0; recv_stall_pct = 48; write_key_limit(8'd255); end
        default: begin send_idle_pct = 35; recv_stall_pct = 35;
                       write_key_limit(8'($urandom_range(1, 127))); end
      endcase
      n = 0;
      while (n < 100) begin
        // mostly a clear, some loads, then queries
        if ($urandom_range(4) != 0) push(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        for (int i = $urandom_range(1, $urandom_range(1) ? 8 : 34); i > 0; i--) begin
          queue_item(rand_note());
          n++;
        end
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          c = rand_query();
          if ($urandom_range(9) == 0) c.mode = 3'($urandom_range(5, 7));
          queue_item(c);
          n++;
        end
      end
      if (ph == 2) begin
        // let the block drain fully before resuming
        while (pending_q.size() > 20) @(posedge clk_i);
        hold_send = 1'b1;
        while (in_ch.valid || expected_q.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/nts_pkg.sv
hdl/nts_in_if.sv
hdl/nts_out_if.sv
hdl/nts_cfg_if.sv
hdl/nts_datapath.sv
hdl/nts_ctrl.sv
hdl/note_table_search_sort.sv
tb/tb.sv
